// ===== rtl/b2f_pkg.sv =====
// ----------------------------------------------------------------------------
// b2f_pkg
// shared types, widths and the factorial table for the factoradic converter
// ----------------------------------------------------------------------------
package b2f_pkg;

   localparam int VALUE_W        = 63;
   localparam int DIGIT_W        = 5;
   localparam int SYMBOL_W       = 7;
   localparam int POS_W          = 5;
   localparam int TABLE_TOP      = 20;
   localparam int MAX_DIGITS_DEF = 20;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [SYMBOL_W-1:0] ASCII_ZERO   = SYMBOL_W'(48);
   localparam logic [SYMBOL_W-1:0] ASCII_LETTER = SYMBOL_W'(55);
   localparam logic [DIGIT_W-1:0]  DECIMAL_TOP  = DIGIT_W'(10);

   // work handed from the front to the back
   typedef struct packed {
      logic [VALUE_W-1:0] rest;
      logic [POS_W-1:0]   lead;   // zero marks a zero input
   } job_type;

   typedef struct packed {
      logic [DIGIT_W-1:0]  digit;
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
   } result_type;

   function automatic logic [VALUE_W-1:0] fac_val(input logic [POS_W-1:0] k);
      logic [VALUE_W-1:0] f;
      case (k)
         5'd0:    f = 63'd1;
         5'd1:    f = 63'd1;
         5'd2:    f = 63'd2;
         5'd3:    f = 63'd6;
         5'd4:    f = 63'd24;
         5'd5:    f = 63'd120;
         5'd6:    f = 63'd720;
         5'd7:    f = 63'd5040;
         5'd8:    f = 63'd40320;
         5'd9:    f = 63'd362880;
         5'd10:   f = 63'd3628800;
         5'd11:   f = 63'd39916800;
         5'd12:   f = 63'd479001600;
         5'd13:   f = 63'd6227020800;
         5'd14:   f = 63'd87178291200;
         5'd15:   f = 63'd1307674368000;
         5'd16:   f = 63'd20922789888000;
         5'd17:   f = 63'd355687428096000;
         5'd18:   f = 63'd6402373705728000;
         5'd19:   f = 63'd121645100408832000;
         5'd20:   f = 63'd2432902008176640000;
         default: f = '1;
      endcase
      return f;
   endfunction

   function automatic logic [SYMBOL_W-1:0] digit_symbol(input logic [DIGIT_W-1:0] d);
      logic [SYMBOL_W-1:0] s;
      if (d < DECIMAL_TOP) begin
         s = SYMBOL_W'(d) + ASCII_ZERO;
      end else begin
         s = SYMBOL_W'(d) + ASCII_LETTER;
      end
      return s;
   endfunction

endpackage

// ===== rtl/b2f_fifo.sv =====
// ----------------------------------------------------------------------------
// b2f_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module b2f_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/b2f_front.sv =====
// ----------------------------------------------------------------------------
// b2f_front
// takes a value and finds its leading factorial position, one compare a cycle
// ----------------------------------------------------------------------------
module b2f_front import b2f_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [VALUE_W-1:0] req_value,
   output logic               req_full,
   output logic               job_push,
   output job_type            job_data,
   input  logic               job_full
);

   localparam logic [POS_W-1:0] LIM = POS_W'(MAX_DIGITS);

   typedef enum logic [0:0] {IDLE, SEARCH} state_type;

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] rest_ff, rest_in;
   logic [POS_W-1:0]   lead_ff, lead_in;
   logic [POS_W-1:0]   next_pos;
   logic               grow;

   assign next_pos = lead_ff + 1'b1;
   assign grow     = (lead_ff < LIM) && (fac_val(next_pos) <= rest_ff);
   assign req_full = (state_ff != IDLE);
   assign job_push = (state_ff == SEARCH) && !grow;
   assign job_data = '{rest: rest_ff, lead: lead_ff};

   always_comb begin
      state_in = state_ff;
      rest_in  = rest_ff;
      lead_in  = lead_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_push) begin
               rest_in  = req_value;
               lead_in  = '0;
               state_in = SEARCH;
            end
         end
         SEARCH: begin
            if (grow) begin
               lead_in = next_pos;
            end else if (!job_full) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      rest_ff <= rest_in;
      lead_ff <= lead_in;
   end

endmodule

// ===== rtl/b2f_back.sv =====
// ----------------------------------------------------------------------------
// b2f_back
// restoring division by the factorial of each position, digit by digit
// ----------------------------------------------------------------------------
module b2f_back import b2f_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_empty,
   input  job_type    job_data,
   output logic       job_pop,
   output logic       res_push,
   output result_type res_data,
   input  logic       res_full
);

   localparam logic [POS_W-1:0] LIM     = POS_W'(MAX_DIGITS);
   localparam logic             MAY_SAT = (MAX_DIGITS < TABLE_TOP);
   localparam int               STEP_W  = $clog2(VALUE_W + 1);
   localparam logic [STEP_W-1:0] SHORT_STEPS = STEP_W'(DIGIT_W);
   localparam logic [STEP_W-1:0] LONG_STEPS  = STEP_W'(VALUE_W);
   localparam logic [DIGIT_W-1:0] DIGIT_SAT  = '1;

   typedef enum logic [1:0] {IDLE, LOAD, DIV, EMIT} state_type;

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;       // partial remainder
   logic [VALUE_W-1:0] shreg_ff, shreg_in;   // dividend bits still to enter
   logic [VALUE_W-1:0] div_ff, div_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [DIGIT_W-1:0] qr_ff, qr_in;
   logic               sat_ff, sat_in;
   logic               wide;
   logic [VALUE_W:0]   trial;
   logic [VALUE_W:0]   diff;
   logic               ge;
   logic [DIGIT_W-1:0] digit;

   // leading digit may overflow only when the position is capped
   assign wide  = MAY_SAT && (pos_ff == LIM);
   assign trial = {acc_ff, shreg_ff[VALUE_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = (trial >= {1'b0, div_ff});
   assign digit = sat_ff ? DIGIT_SAT : qr_ff;

   assign job_pop  = (state_ff == IDLE) && !job_empty;
   assign res_push = (state_ff == EMIT);
   assign res_data = '{digit: digit, symbol: digit_symbol(digit), last: (pos_ff <= 5'd1)};

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      shreg_in = shreg_ff;
      div_in   = div_ff;
      pos_in   = pos_ff;
      steps_in = steps_ff;
      qr_in    = qr_ff;
      sat_in   = sat_ff;
      unique case (state_ff)
         IDLE: begin
            if (!job_empty) begin
               acc_in = job_data.rest;
               pos_in = job_data.lead;
               qr_in  = '0;
               sat_in = 1'b0;
               // a zero input goes straight out as a single zero digit
               state_in = (job_data.lead == '0) ? EMIT : LOAD;
            end
         end
         LOAD: begin
            div_in = fac_val(pos_ff);
            qr_in  = '0;
            sat_in = 1'b0;
            if (wide) begin
               acc_in   = '0;
               shreg_in = acc_ff;
               steps_in = LONG_STEPS;
            end else begin
               acc_in   = {{DIGIT_W{1'b0}}, acc_ff[VALUE_W-1:DIGIT_W]};
               shreg_in = {acc_ff[DIGIT_W-1:0], {(VALUE_W-DIGIT_W){1'b0}}};
               steps_in = SHORT_STEPS;
            end
            state_in = DIV;
         end
         DIV: begin
            acc_in   = ge ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
            shreg_in = {shreg_ff[VALUE_W-2:0], 1'b0};
            qr_in    = {qr_ff[DIGIT_W-2:0], ge};
            sat_in   = sat_ff || qr_ff[DIGIT_W-1];
            steps_in = steps_ff - 1'b1;
            if (steps_ff == STEP_W'(1)) begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (!res_full) begin
               if (pos_ff <= 5'd1) begin
                  state_in = IDLE;
               end else begin
                  pos_in   = pos_ff - 1'b1;
                  state_in = LOAD;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff   <= acc_in;
      shreg_ff <= shreg_in;
      div_ff   <= div_in;
      pos_ff   <= pos_in;
      steps_ff <= steps_in;
      qr_ff    <= qr_in;
      sat_ff   <= sat_in;
   end

endmodule

// ===== rtl/binary_to_factoradic_digits.sv =====
// ----------------------------------------------------------------------------
// binary_to_factoradic_digits
// converts a 63-bit value to factorial-base digits, most significant first
// ----------------------------------------------------------------------------
//  channel   ports                                   beat
//  request   req_push, req_full, req_value           one value to convert
//  response  rsp_pop, rsp_empty, rsp_digit/symbol/   one digit, last on 1!
//            rsp_last
//
//  the front makes one factorial compare per cycle to find the leading
//  position, then hands the job to a 2-beat queue
//  the back works each digit through load, 5 restoring steps and emit; a capped
//  leading digit takes 63 steps instead
//  reset is synchronous and clears only control state; there is no config
//  either side may stall: the job queue and the 2-beat response queue decouple
// ----------------------------------------------------------------------------
module binary_to_factoradic_digits import b2f_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                req_full,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic [DIGIT_W-1:0]  rsp_digit,
   output logic [SYMBOL_W-1:0] rsp_symbol,
   output logic                rsp_last
);

   // front to job queue
   logic       fq_push, fq_full;
   job_type    fq_data;
   // job queue to back
   logic       bq_pop, bq_empty;
   logic [$bits(job_type)-1:0] bq_raw;
   // back to response queue
   logic       rq_push, rq_full;
   result_type rq_data;
   logic [$bits(result_type)-1:0] rsp_raw;
   result_type rsp_data;

   // classify: leading position search
   b2f_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_value (req_value),
      .req_full  (req_full),
      .job_push  (fq_push),
      .job_data  (fq_data),
      .job_full  (fq_full)
   );

   // short queue between front and back
   b2f_fifo #(.WIDTH($bits(job_type)), .DEPTH(QUEUE_DEPTH)) u_job_q (
      .clock   (clock),
      .reset   (reset),
      .push    (fq_push),
      .wr_data (fq_data),
      .full    (fq_full),
      .pop     (bq_pop),
      .rd_data (bq_raw),
      .empty   (bq_empty)
   );

   // digit division
   b2f_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (bq_empty),
      .job_data  (job_type'(bq_raw)),
      .job_pop   (bq_pop),
      .res_push  (rq_push),
      .res_data  (rq_data),
      .res_full  (rq_full)
   );

   // response queue, oldest digit shown while not empty
   b2f_fifo #(.WIDTH($bits(result_type)), .DEPTH(QUEUE_DEPTH)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rq_push),
      .wr_data (rq_data),
      .full    (rq_full),
      .pop     (rsp_pop),
      .rd_data (rsp_raw),
      .empty   (rsp_empty)
   );

   assign rsp_data   = result_type'(rsp_raw);
   assign rsp_digit  = rsp_data.digit;
   assign rsp_symbol = rsp_data.symbol;
   assign rsp_last   = rsp_data.last;

endmodule
